// ----- hw/rtl/s5rp_pkg.sv -----
// Shared types and constants for the SOCKS5 request parser.
`timescale 1ns / 1ps
package s5rp_pkg;

  localparam logic [7:0] SOCKS_VERSION = 8'h05;
  localparam logic [7:0] ATYP_IPV4     = 8'd1;
  localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
  localparam logic [7:0] ATYP_IPV6     = 8'd4;
  localparam logic [7:0] IPV4_LEN      = 8'd4;
  localparam logic [7:0] IPV6_LEN      = 8'd16;
  localparam logic [7:0] PORT_LEN      = 8'd2;

  localparam int S5RP_QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    PH_VERSION = 4'd0,
    PH_CMD     = 4'd1,
    PH_RSV     = 4'd2,
    PH_ATYP    = 4'd3,
    PH_DLEN    = 4'd4,
    PH_ADDR    = 4'd5,
    PH_PORT    = 4'd6,
    PH_DONE    = 4'd7,
    PH_BADVER  = 4'd8,
    PH_BADATYP = 4'd9,
    PH_ERROR   = 4'd10
  } s5rp_phase_t;

  typedef enum logic [1:0] {
    AT_IPV4   = 2'd0,
    AT_IPV6   = 2'd1,
    AT_DOMAIN = 2'd2,
    AT_OTHER  = 2'd3
  } s5rp_atyp_t;

  // One classified word as it travels through the queue
  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       ver_ok;
    s5rp_atyp_t atyp;
    logic       zero_len;
  } s5rp_word_t;

  // Queue occupancy flags seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } s5rp_q_stat_t;

endpackage

// ----- hw/rtl/s5rp_front.sv -----
// Front end: accept input words and classify each byte before queueing.
`timescale 1ns / 1ps
module s5rp_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_restart,
  input  s5rp_pkg::s5rp_q_stat_t q_stat,
  output logic                 push,
  output s5rp_pkg::s5rp_word_t push_word
);
  import s5rp_pkg::*;

  s5rp_atyp_t atyp_cls;

  always_comb begin
    unique case (in_data_byte)
      ATYP_IPV4:   atyp_cls = AT_IPV4;
      ATYP_IPV6:   atyp_cls = AT_IPV6;
      ATYP_DOMAIN: atyp_cls = AT_DOMAIN;
      default:     atyp_cls = AT_OTHER;
    endcase
  end

  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    push_word.data     = in_data_byte;
    push_word.restart  = in_restart;
    push_word.ver_ok   = (in_data_byte == SOCKS_VERSION);
    push_word.atyp     = atyp_cls;
    push_word.zero_len = (in_data_byte == 8'd0);
  end

endmodule

// ----- hw/rtl/s5rp_queue.sv -----
// Short queue of classified words between front and back.
`timescale 1ns / 1ps
module s5rp_queue #(
  parameter int DEPTH = s5rp_pkg::S5RP_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  s5rp_pkg::s5rp_word_t   push_word,
  input  logic                   pop,
  output s5rp_pkg::s5rp_word_t   head_word,
  output s5rp_pkg::s5rp_q_stat_t q_stat
);
  import s5rp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  s5rp_word_t       slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_word;
    end
  end

  assign head_word    = slots_r[rd_ptr_r];
  assign q_stat.full  = (count_r == FULL_CNT);
  assign q_stat.empty = (count_r == '0);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

// ----- hw/rtl/s5rp_back.sv -----
// Back end: parser state machine and registered result word.
`timescale 1ns / 1ps
module s5rp_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  s5rp_pkg::s5rp_word_t   head_word,
  input  s5rp_pkg::s5rp_q_stat_t q_stat,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [3:0]             out_status,
  output logic [7:0]             out_command,
  output logic [7:0]             out_address_type,
  output logic [7:0]             out_address_byte,
  output logic [7:0]             out_address_index,
  output logic                   out_address_byte_valid,
  output logic [7:0]             out_address_length,
  output logic [15:0]            out_port,
  output logic                   out_finished,
  output logic                   out_errored
);
  import s5rp_pkg::*;

  s5rp_phase_t phase_r, phase_nxt;
  logic [7:0]  seen_r, seen_nxt;
  logic [7:0]  exp_r, exp_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  atyp_r, atyp_nxt;
  logic [15:0] port_r, port_nxt;
  logic [7:0]  seen_inc;
  logic [7:0]  abyte, aidx;
  logic        avalid;

  logic        out_valid_r;
  s5rp_phase_t status_r;
  logic [7:0]  o_cmd_r, o_atyp_r, o_abyte_r, o_aidx_r, o_alen_r;
  logic        o_avalid_r;
  logic [15:0] o_port_r;

  // Advance when a word waits and the result slot is free or being drained
  assign pop      = !q_stat.empty && (!out_valid_r || out_ready);
  assign seen_inc = seen_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    seen_nxt  = seen_r;
    exp_nxt   = exp_r;
    cmd_nxt   = cmd_r;
    atyp_nxt  = atyp_r;
    port_nxt  = port_r;
    abyte     = 8'd0;
    aidx      = 8'd0;
    avalid    = 1'b0;
    if (pop) begin
      if (head_word.restart) begin
        phase_nxt = PH_VERSION;
        seen_nxt  = 8'd0;
        exp_nxt   = 8'd0;
        cmd_nxt   = 8'd0;
        atyp_nxt  = 8'd0;
        port_nxt  = 16'd0;
      end else begin
        unique case (phase_r)
          PH_VERSION: phase_nxt = head_word.ver_ok ? PH_CMD : PH_BADVER;
          PH_CMD: begin
            cmd_nxt   = head_word.data;
            phase_nxt = PH_RSV;
          end
          PH_RSV: phase_nxt = PH_ATYP;
          PH_ATYP: begin
            atyp_nxt = head_word.data;
            seen_nxt = 8'd0;
            unique case (head_word.atyp)
              AT_IPV4: begin
                exp_nxt   = IPV4_LEN;
                phase_nxt = PH_ADDR;
              end
              AT_IPV6: begin
                exp_nxt   = IPV6_LEN;
                phase_nxt = PH_ADDR;
              end
              AT_DOMAIN: phase_nxt = PH_DLEN;
              default:   phase_nxt = PH_BADATYP;
            endcase
          end
          PH_DLEN: begin
            seen_nxt  = 8'd0;
            exp_nxt   = head_word.data;
            phase_nxt = head_word.zero_len ? PH_ERROR : PH_ADDR;
          end
          PH_ADDR: begin
            abyte  = head_word.data;
            aidx   = seen_r;
            avalid = 1'b1;
            if (seen_inc >= exp_r) begin
              seen_nxt  = 8'd0;
              port_nxt  = 16'd0;
              phase_nxt = PH_PORT;
            end else begin
              seen_nxt = seen_inc;
            end
          end
          PH_PORT: begin
            port_nxt = {port_r[7:0], head_word.data};
            seen_nxt = seen_inc;
            if (seen_inc >= PORT_LEN) begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DONE, PH_BADVER, PH_BADATYP, PH_ERROR: phase_nxt = phase_r;
          default: phase_nxt = PH_ERROR;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_VERSION;
      seen_r      <= 8'd0;
      exp_r       <= 8'd0;
      cmd_r       <= 8'd0;
      atyp_r      <= 8'd0;
      port_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      seen_r   <= seen_nxt;
      exp_r    <= exp_nxt;
      cmd_r    <= cmd_nxt;
      atyp_r   <= atyp_nxt;
      port_r   <= port_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r   <= phase_nxt;
      o_cmd_r    <= cmd_nxt;
      o_atyp_r   <= atyp_nxt;
      o_abyte_r  <= abyte;
      o_aidx_r   <= aidx;
      o_avalid_r <= avalid;
      o_alen_r   <= exp_nxt;
      o_port_r   <= port_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = status_r;
  assign out_command            = o_cmd_r;
  assign out_address_type       = o_atyp_r;
  assign out_address_byte       = o_abyte_r;
  assign out_address_index      = o_aidx_r;
  assign out_address_byte_valid = o_avalid_r;
  assign out_address_length     = o_alen_r;
  assign out_port               = o_port_r;
  assign out_finished           = (status_r == PH_DONE);
  assign out_errored            = (status_r == PH_BADVER) || (status_r == PH_BADATYP) ||
                                  (status_r == PH_ERROR);

  a_addr_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ADDR |-> seen_r < exp_r)
    else $error("address count reached its end inside the address phase");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !head_word.restart && phase_r == PH_DONE) |=> phase_r == PH_DONE)
    else $error("done phase left without restart");

  a_abyte_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_avalid_r) |-> (status_r == PH_ADDR || status_r == PH_PORT))
    else $error("address byte flagged outside address handling");

  a_no_pop_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !pop)
    else $error("result overwritten while stalled");

endmodule

// ----- hw/rtl/socks5_request_parser_top.sv -----
// Top level of the SOCKS5 request parser: front, queue and back joined.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in_     | input     | in_valid / in_ready    | data_byte[7:0], restart
//  out_    | output    | out_valid / out_ready  | status, command, address fields, port,
//          |           |                        | finished, errored
//
// One word in, one result word out; one word per cycle sustained while out_ready stays high.
// The accepting edge writes the queue; the edge that pops the word runs the parser step
// and loads the result register.
// Synchronous active-low reset returns the parser to expect-version and empties the queue.
// A stalled result holds in its register; the queue absorbs up to QUEUE_DEPTH words
// before in_ready drops.
`timescale 1ns / 1ps
module socks5_request_parser_top #(
  parameter int QUEUE_DEPTH = s5rp_pkg::S5RP_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic [7:0]  out_command,
  output logic [7:0]  out_address_type,
  output logic [7:0]  out_address_byte,
  output logic [7:0]  out_address_index,
  output logic        out_address_byte_valid,
  output logic [7:0]  out_address_length,
  output logic [15:0] out_port,
  output logic        out_finished,
  output logic        out_errored
);
  import s5rp_pkg::*;

  // Words crossing from front to back
  logic         push;
  logic         pop;
  s5rp_word_t   push_word;
  s5rp_word_t   head_word;
  s5rp_q_stat_t q_stat;

  // Classify the byte (version check, address type, zero length) on the way in
  s5rp_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_restart   (in_restart),
    .q_stat       (q_stat),
    .push         (push),
    .push_word    (push_word)
  );

  // Decouple acceptance from result back-pressure
  s5rp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head_word (head_word),
    .q_stat    (q_stat)
  );

  // Step the parser once per popped word and hold the result until taken
  s5rp_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .head_word              (head_word),
    .q_stat                 (q_stat),
    .pop                    (pop),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_command            (out_command),
    .out_address_type       (out_address_type),
    .out_address_byte       (out_address_byte),
    .out_address_index      (out_address_index),
    .out_address_byte_valid (out_address_byte_valid),
    .out_address_length     (out_address_length),
    .out_port               (out_port),
    .out_finished           (out_finished),
    .out_errored            (out_errored)
  );

endmodule

// ----- bench/socks5_request_parser_top_test.sv -----
// Self-checking bench for the SOCKS5 request parser: directed rows, random requests, stalls.
`timescale 1ns / 1ps
module socks5_request_parser_top_test;
  import s5rp_pkg::*;

  // Handshake-free cycles before the run is declared hung; far above the
  // longest correct quiet stretch (the long hold-off plus a full queue).
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to linger once nothing is outstanding.
  localparam int TAIL_CYCLES    = 16;
  localparam int RANDOM_WORDS   = 1200;
  localparam int LONG_HOLD      = 100;
  localparam int HOLD_AFTER     = 300;
  localparam int DIRECTED_ROWS  = 26;

  // One stimulus word. Pinned rows carry a hand-typed status and flags that
  // override the parse prediction for those three fields.
  typedef struct packed {
    logic [7:0]  data;
    logic        restart;
    logic        pinned;
    s5rp_phase_t status;
    logic        finished;
    logic        errored;
  } stim_row_t;

  // One expected result word, at the block's own widths.
  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  command;
    logic [7:0]  address_type;
    logic [7:0]  address_byte;
    logic [7:0]  address_index;
    logic        address_byte_valid;
    logic [7:0]  address_length;
    logic [15:0] port;
    logic        finished;
    logic        errored;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_status;
  logic [7:0]  out_command;
  logic [7:0]  out_address_type;
  logic [7:0]  out_address_byte;
  logic [7:0]  out_address_index;
  logic        out_address_byte_valid;
  logic [7:0]  out_address_length;
  logic [15:0] out_port;
  logic        out_finished;
  logic        out_errored;

  socks5_request_parser_top i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_data_byte           (in_data_byte),
    .in_restart             (in_restart),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_command            (out_command),
    .out_address_type       (out_address_type),
    .out_address_byte       (out_address_byte),
    .out_address_index      (out_address_index),
    .out_address_byte_valid (out_address_byte_valid),
    .out_address_length     (out_address_length),
    .out_port               (out_port),
    .out_finished           (out_finished),
    .out_errored            (out_errored)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hold reset from the start, then release it for good
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Parser shadow state, advanced once per accepted word
  s5rp_phase_t ps_phase   = PH_VERSION;
  logic [7:0]  ps_seen    = 8'd0;
  logic [7:0]  ps_need    = 8'd0;
  logic [7:0]  ps_command = 8'd0;
  logic [7:0]  ps_atyp    = 8'd0;
  logic [15:0] ps_port    = 16'd0;

  stim_row_t     req_words[$];
  parse_result_t pending_results[$];

  int n_accepted = 0;
  int n_results  = 0;
  int n_errors   = 0;
  int n_parsed   = 0;
  int n_failed   = 0;
  bit stim_done  = 1'b0;

  // Directed rows: restart, bad version, unknown address type, zero-length
  // domain, then a full IPv4 request to done and one sticky word after it.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'hFF, 1'b1, 1'b1, PH_VERSION, 1'b0, 1'b0},
    '{8'h04, 1'b0, 1'b1, PH_BADVER,  1'b0, 1'b1},
    '{8'h00, 1'b0, 1'b1, PH_BADVER,  1'b0, 1'b1},
    '{8'h00, 1'b1, 1'b1, PH_VERSION, 1'b0, 1'b0},
    '{8'h05, 1'b0, 1'b0, PH_VERSION, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, PH_VERSION, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, PH_VERSION, 1'b0, 1'b0},
    '{8'h02, 1'b0, 1'b1, PH_BADATYP, 1'b0, 1'b1},
    '{8'h5A, 1'b1, 1'b1, PH_VERSION, 1'b0, 1'b0},
    '{8'h05, 1'b0, 1'b0, PH_VERSION, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, PH_VERSION, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, PH_VERSION, 1'b0, 1'b0},
    '{8'h03, 1'b0, 1'b1, PH_DLEN,    1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b1, PH_ERROR,   1'b0, 1'b1},
    '{8'h00, 1'b1, 1'b1, PH_VERSION, 1'b0, 1'b0},
    '{8'h05, 1'b0, 1'b0, PH_VERSION, 1'b0, 1'b0},
    '{8'h01, 1'b0, 1'b0, PH_VERSION, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, PH_VERSION, 1'b0, 1'b0},
    '{8'h01, 1'b0, 1'b1, PH_ADDR,    1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, PH_VERSION, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, PH_VERSION, 1'b0, 1'b0},
    '{8'hAA, 1'b0, 1'b0, PH_VERSION, 1'b0, 1'b0},
    '{8'h55, 1'b0, 1'b0, PH_VERSION, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, PH_VERSION, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b1, PH_DONE,    1'b1, 1'b0},
    '{8'h33, 1'b0, 1'b1, PH_DONE,    1'b1, 1'b0}
  };

  function automatic stim_row_t plain_word(input logic [7:0] data, input logic restart);
    plain_word = '{data, restart, 1'b0, PH_VERSION, 1'b0, 1'b0};
  endfunction

  // Advance the shadow parser by one word and return the result it implies
  function automatic parse_result_t parse_step(input logic [7:0] c, input logic restart);
    parse_result_t r;
    s5rp_phase_t   was;
    r   = '0;
    was = ps_phase;
    if (restart) begin
      ps_phase   = PH_VERSION;
      ps_seen    = 8'd0;
      ps_need    = 8'd0;
      ps_command = 8'd0;
      ps_atyp    = 8'd0;
      ps_port    = 16'd0;
    end else begin
      case (ps_phase)
        PH_VERSION: ps_phase = (c == SOCKS_VERSION) ? PH_CMD : PH_BADVER;
        PH_CMD: begin
          ps_command = c;
          ps_phase   = PH_RSV;
        end
        PH_RSV: ps_phase = PH_ATYP;
        PH_ATYP: begin
          ps_atyp = c;
          ps_seen = 8'd0;
          if (c == ATYP_IPV4) begin
            ps_need  = IPV4_LEN;
            ps_phase = PH_ADDR;
          end else if (c == ATYP_IPV6) begin
            ps_need  = IPV6_LEN;
            ps_phase = PH_ADDR;
          end else if (c == ATYP_DOMAIN) begin
            ps_phase = PH_DLEN;
          end else begin
            ps_phase = PH_BADATYP;
          end
        end
        PH_DLEN: begin
          ps_seen  = 8'd0;
          ps_need  = c;
          ps_phase = (c == 8'd0) ? PH_ERROR : PH_ADDR;
        end
        PH_ADDR: begin
          r.address_byte       = c;
          r.address_index      = ps_seen;
          r.address_byte_valid = 1'b1;
          ps_seen = ps_seen + 8'd1;
          if (ps_seen >= ps_need) begin
            ps_seen  = 8'd0;
            ps_port  = 16'd0;
            ps_phase = PH_PORT;
          end
        end
        PH_PORT: begin
          ps_port = {ps_port[7:0], c};
          ps_seen = ps_seen + 8'd1;
          if (ps_seen >= PORT_LEN) ps_phase = PH_DONE;
        end
        PH_DONE, PH_BADVER, PH_BADATYP, PH_ERROR: ;
        default: ps_phase = PH_ERROR;
      endcase
    end
    if (ps_phase == PH_DONE && was != PH_DONE) n_parsed++;
    if (ps_phase >= PH_BADVER && was < PH_BADVER) n_failed++;
    r.status         = ps_phase;
    r.command        = ps_command;
    r.address_type   = ps_atyp;
    r.address_length = ps_need;
    r.port           = ps_port;
    r.finished       = (ps_phase == PH_DONE);
    r.errored        = (ps_phase >= PH_BADVER);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Build the stimulus, then feed it word by word with random gaps
  initial begin : word_feed
    int          pick;
    int          keep;
    int          gap;
    logic [7:0]  atyp;
    logic [7:0]  alen;
    logic [7:0]  frame[$];

    foreach (directed_rows[i]) req_words.push_back(directed_rows[i]);

    // Mostly well-formed requests with random content; the rest is noise,
    // bad versions, unknown address types and requests cut short.
    while (req_words.size() < DIRECTED_ROWS + RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      frame.delete();
      if (pick < 8) begin
        repeat ($urandom_range(1, 8))
          req_words.push_back(plain_word(8'($urandom), $urandom_range(0, 7) == 0));
      end else begin
        // usually open with a restart so the request starts clean
        if ($urandom_range(0, 9) != 0) req_words.push_back(plain_word(8'($urandom), 1'b1));
        frame.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : SOCKS_VERSION);
        frame.push_back(8'($urandom));
        frame.push_back(8'($urandom));
        pick = $urandom_range(0, 19);
        if (pick < 7)       atyp = ATYP_IPV4;
        else if (pick < 13) atyp = ATYP_IPV6;
        else if (pick < 18) atyp = ATYP_DOMAIN;
        else                atyp = 8'($urandom);
        frame.push_back(atyp);
        if (atyp == ATYP_DOMAIN) begin
          // keep names short; the empty and the longest name turn up now and then
          pick = $urandom_range(0, 15);
          alen = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(1, 24));
          frame.push_back(alen);
        end else begin
          alen = (atyp == ATYP_IPV4) ? IPV4_LEN : (atyp == ATYP_IPV6) ? IPV6_LEN : 8'd0;
        end
        repeat (alen) frame.push_back(8'($urandom));
        // port, plus a few trailing words to exercise the sticky end
        repeat (int'(PORT_LEN) + $urandom_range(0, 2)) frame.push_back(8'($urandom));
        keep = ($urandom_range(0, 9) == 0) ? $urandom_range(1, frame.size()) : frame.size();
        for (int k = 0; k < keep; k++) req_words.push_back(plain_word(frame[k], 1'b0));
      end
    end

    wait (rst_n);
    foreach (req_words[i]) begin
      // bursts with no gaps every fourth block of 64 words
      gap = ((i / 64) % 4 == 1) ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid     <= 1'b1;
      in_data_byte <= req_words[i].data;
      in_restart   <= req_words[i].restart;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid  <= 1'b0;
    stim_done = 1'b1;
  end

  // Drain results with random stalls; once, hold off long enough that the
  // queue fills and the block drops in_ready while words keep coming.
  initial begin : result_drain
    int stall;
    bit held_off;
    held_off = 1'b0;
    wait (rst_n);
    forever begin
      if (!held_off && n_results >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = ((n_results / 64) % 4 == 2) ? 0 : $urandom_range(0, 12);
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Predict on every accepted word; pinned rows take their typed status
  always @(posedge clk) begin : word_accept
    parse_result_t r;
    if (rst_n && in_valid && in_ready) begin
      r = parse_step(in_data_byte, in_restart);
      if (req_words[n_accepted].pinned) begin
        r.status   = req_words[n_accepted].status;
        r.finished = req_words[n_accepted].finished;
        r.errored  = req_words[n_accepted].errored;
      end
      pending_results.push_back(r);
      n_accepted++;
    end
  end

  // Compare every result word against the oldest outstanding prediction
  always @(posedge clk) begin : result_check
    parse_result_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: result word, expected none, got status %0d", $time, out_status);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 16'(want.status), 16'(out_status));
        check_field("command", 16'(want.command), 16'(out_command));
        check_field("address_type", 16'(want.address_type), 16'(out_address_type));
        check_field("address_byte", 16'(want.address_byte), 16'(out_address_byte));
        check_field("address_index", 16'(want.address_index), 16'(out_address_index));
        check_field("address_byte_valid", 16'(want.address_byte_valid),
                    16'(out_address_byte_valid));
        check_field("address_length", 16'(want.address_length), 16'(out_address_length));
        check_field("port", want.port, out_port);
        check_field("finished", 16'(want.finished), 16'(out_finished));
        check_field("errored", 16'(want.errored), 16'(out_errored));
      end
    end
  end

  // Abort if no word moves on either side for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Wait for every prediction to be met, then linger for stray results
  initial begin : run_end
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Fed %0d request words and checked %0d result words.", n_accepted, n_results);
    $display("Requests parsed through the port: %0d; requests ending in an error phase: %0d.",
             n_parsed, n_failed);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/s5rp_pkg.sv
hw/rtl/s5rp_front.sv
hw/rtl/s5rp_queue.sv
hw/rtl/s5rp_back.sv
hw/rtl/socks5_request_parser_top.sv
bench/socks5_request_parser_top_test.sv
